### design/conv_encode_interleave_unit_defines.svh
// Assertion macros for the convolutional encoder and interleaver.
// Included by conv_encode_interleave_unit.sv; depends on nothing else.
`ifndef CONV_ENCODE_INTERLEAVE_UNIT_DEFINES_SVH
`define CONV_ENCODE_INTERLEAVE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define CEI_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// Next-cycle implication, held off during reset.
`define CEI_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define CEI_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define CEI_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

### design/cei_pkg.sv
// Package for the convolutional encoder and interleaver: symbol table,
// byte encoder and interleave permutation. No dependencies.
`timescale 1ns / 1ps

package cei_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned HIST_W = 3;
    localparam int unsigned SYM_W  = 2 * BYTE_W;
    localparam int unsigned WORD_W = 2 * SYM_W;

    // Rate 1/2, K=4 output pairs, indexed by {history, bit}
    localparam logic [1:0] SYMBOL_TABLE [16] = '{
        2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1,
        2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3, 2'd1, 2'd2
    };

    typedef struct packed {
        logic [SYM_W-1:0]  symbols;
        logic [HIST_W-1:0] history;
    } enc_result_t;

    // Encodes one byte MSB first; first symbol lands in the top bits.
    function automatic enc_result_t encode_byte(input logic [HIST_W-1:0] hist_in,
                                                input logic [BYTE_W-1:0] b);
        enc_result_t       r;
        logic [HIST_W-1:0] h;
        logic [SYM_W-1:0]  s;
        logic              bit_v;
        h = hist_in;
        s = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            bit_v = b[BYTE_W-1-i];
            s     = {s[SYM_W-3:0], SYMBOL_TABLE[{h, bit_v}]};
            h     = {h[HIST_W-2:0], bit_v};
        end
        r.symbols = s;
        r.history = h;
        return r;
    endfunction

    // Symbol permutation over a 32-bit pair word; pure wiring.
    function automatic logic [WORD_W-1:0] interleave_word(input logic [WORD_W-1:0] enc);
        logic [WORD_W-1:0] r;
        int                sh;
        r = '0;
        for (int k = 0; k < 16; k++)
        begin
            sh = ((k & 3) << 3) + ((k & 12) >> 1);
            r[WORD_W-1-2*k -: 2] = enc[sh +: 2];
        end
        return r;
    endfunction

endpackage

### design/conv_encode_interleave_unit.sv
// Rate 1/2 K=4 convolutional encoder with two-byte symbol interleaver (top level).
// Depends on cei_pkg and conv_encode_interleave_unit_defines.svh.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, data_byte,            | byte in
//          | whiten_byte, last                         |
//  output  | out_valid, out_stall, coded_word,         | word out
//          | last_word                                 |
//
// One byte per cycle sustained unless out_stall holds the output: a transfer lands in
// the input register and is encoded combinationally (8-step trellis, fixed permutation).
// A first byte's symbols are held; the closing byte's word goes to the output register.
// Reset (rst_n low, asynchronous) empties both registers, clears the history
// and expects the first byte of a pair.
// in_stall is high only while a byte waits behind a word held by out_stall.
`timescale 1ns / 1ps
`include "conv_encode_interleave_unit_defines.svh"

module conv_encode_interleave_unit (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  whiten_byte,
    input  logic        last,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] coded_word,
    output logic        last_word
);

    // Input register
    logic                            s1_valid_reg, s1_valid_next;
    logic [cei_pkg::BYTE_W-1:0]      s1_byte_reg;
    logic                            s1_last_reg;

    // Encoder state
    logic [cei_pkg::HIST_W-1:0]      history_reg, history_next;
    logic [cei_pkg::SYM_W-1:0]       held_reg, held_next;
    logic                            second_reg, second_next;

    // Output register
    logic                            out_valid_reg, out_valid_next;
    logic [cei_pkg::WORD_W-1:0]      word_reg;
    logic                            last_word_reg;

    logic                            in_fire;
    logic                            s1_fire;
    logic                            produce;
    logic [cei_pkg::WORD_W-1:0]      word_next;
    cei_pkg::enc_result_t            enc_a;
    cei_pkg::enc_result_t            enc_b;

    // The stage moves whenever the output register is empty or being emptied.
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_fire  = in_valid && !in_stall;

    // Main byte, then a zero byte from its end history for a lone last byte.
    assign enc_a = cei_pkg::encode_byte(history_reg, s1_byte_reg);
    assign enc_b = cei_pkg::encode_byte(enc_a.history, '0);

    always_comb
    begin
        history_next = history_reg;
        held_next    = held_reg;
        second_next  = second_reg;
        produce      = 1'b0;
        word_next    = '0;
        if (s1_fire)
        begin
            if (!second_reg && !s1_last_reg)
            begin
                // first byte: hold its symbols
                held_next    = enc_a.symbols;
                second_next  = 1'b1;
                history_next = enc_a.history;
            end
            else
            begin
                produce = 1'b1;
                if (second_reg)
                begin
                    word_next = cei_pkg::interleave_word({held_reg, enc_a.symbols});
                end
                else
                begin
                    // last on first byte: pad the pair with an encoded zero byte
                    word_next = cei_pkg::interleave_word({enc_a.symbols, enc_b.symbols});
                end
                held_next    = '0;
                second_next  = 1'b0;
                history_next = s1_last_reg ? '0 : enc_a.history;
            end
        end
    end

    always_comb
    begin
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            history_reg   <= '0;
            held_reg      <= '0;
            second_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            history_reg   <= history_next;
            held_reg      <= held_next;
            second_reg    <= second_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= data_byte ^ whiten_byte;
            s1_last_reg <= last;
        end
        if (produce)
        begin
            word_reg      <= word_next;
            last_word_reg <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign coded_word = word_reg;
    assign last_word  = last_word_reg;

    // A second byte or a last byte always yields a word next cycle.
    `CEI_ASSERT_NEXT(a_pair_completes, clk, rst_n, s1_fire && (second_reg || s1_last_reg), out_valid_reg)
    // After a last byte the trellis restarts and a new pair begins.
    `CEI_ASSERT_NEXT(a_last_clears, clk, rst_n, s1_fire && s1_last_reg, (history_reg == '0) && !second_reg)
    // Input only back-pressures when the output side is blocked.
    `CEI_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, s1_valid_reg && out_valid_reg && out_stall)

endmodule
